[sv/mac_pdu_demultiplexer_unit_defines.svh]
// ---------------------------------------------------------------------------
// MAC PDU demultiplexer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MAC_PDU_DEMULTIPLEXER_UNIT_DEFINES_SVH
`define MAC_PDU_DEMULTIPLEXER_UNIT_DEFINES_SVH

// same-cycle implication
`define MPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mpd_pkg.sv]
// ---------------------------------------------------------------------------
// MAC PDU demultiplexer package
// Parser phases, result kind codes and the records passed between stages.
// ---------------------------------------------------------------------------
package mpd_pkg;

    localparam logic [5:0] MAX_DATA_CHANNEL = 6'd32;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_RESERVED = 2'd2;
    localparam logic [1:0] KIND_TRUNC    = 2'd3;

    typedef enum logic [2:0] {
        PH_SUBHDR    = 3'd0,
        PH_LEN_SHORT = 3'd1,
        PH_LEN_HIGH  = 3'd2,
        PH_LEN_LOW   = 3'd3,
        PH_PAYLOAD   = 3'd4,
        PH_DISCARD   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] pdu_byte;
        logic       end_of_pdu;
    } in_item_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [5:0]  channel;
        logic [15:0] length;
        logic [7:0]  data;
        logic        first;
        logic        last;
    } result_t;

endpackage

[sv/mpd_in_stage.sv]
// ---------------------------------------------------------------------------
// MAC PDU demultiplexer input register
// Holds one accepted byte until the parser consumes it.
// ---------------------------------------------------------------------------
module mpd_in_stage
    import mpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] pdu_byte,
    input  logic       end_of_pdu,
    input  logic       take,
    output logic       item_valid,
    output in_item_t   item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    assign in_ready   = !valid_reg || take;
    assign accept     = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.pdu_byte   <= pdu_byte;
            item_reg.end_of_pdu <= end_of_pdu;
        end
    end

endmodule

[sv/mpd_parser.sv]
// ---------------------------------------------------------------------------
// MAC PDU demultiplexer parser
// Subheader/length/payload state machine; one byte per take.
// ---------------------------------------------------------------------------
module mpd_parser
    import mpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  in_item_t item,
    input  logic     out_space,
    output logic     take,
    output result_t  res
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [5:0]  channel_reg;
    logic [5:0]  channel_next;
    logic [7:0]  len_high_reg;
    logic [7:0]  len_high_next;
    logic [15:0] left_reg;
    logic [15:0] left_next;
    logic [15:0] sdu_len_reg;
    logic [15:0] sdu_len_next;
    logic        first_reg;
    logic        first_next;

    logic [7:0]  b;
    logic        eop;
    logic [5:0]  id;
    logic        id_reserved;
    logic [15:0] full_len;
    logic        last_byte;

    assign b           = item.pdu_byte;
    assign eop         = item.end_of_pdu;
    assign id          = b[5:0];
    assign id_reserved = id > MAX_DATA_CHANNEL;
    assign full_len    = (phase_reg == PH_LEN_LOW) ? {len_high_reg, b} : {8'd0, b};
    assign last_byte   = left_reg <= 16'd1;

    // bytes without a result pass even while the output is stalled
    assign take = item_valid && (!res.valid || out_space);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SUBHDR:
            begin
                if (id_reserved)
                begin
                    phase_next = PH_DISCARD;
                end
                else
                begin
                    phase_next = b[6] ? PH_LEN_HIGH : PH_LEN_SHORT;
                end
            end
            PH_LEN_SHORT, PH_LEN_LOW:
            begin
                phase_next = (full_len == 16'd0) ? PH_SUBHDR : PH_PAYLOAD;
            end
            PH_LEN_HIGH:
            begin
                phase_next = PH_LEN_LOW;
            end
            PH_PAYLOAD:
            begin
                if (last_byte)
                begin
                    phase_next = PH_SUBHDR;
                end
            end
            PH_DISCARD:
            begin
                phase_next = PH_DISCARD;
            end
            default:
            begin
                phase_next = PH_SUBHDR;
            end
        endcase
        if (eop)
        begin
            phase_next = PH_SUBHDR;
        end
    end

    // result and held fields
    always_comb
    begin
        res           = '0;
        channel_next  = channel_reg;
        len_high_next = len_high_reg;
        left_next     = left_reg;
        sdu_len_next  = sdu_len_reg;
        first_next    = first_reg;
        unique case (phase_reg)
            PH_SUBHDR:
            begin
                channel_next = id;
                sdu_len_next = 16'd0;
                res.channel  = id;
                if (id_reserved)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_RESERVED;
                end
                else if (eop)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_TRUNC;
                end
            end
            PH_LEN_SHORT, PH_LEN_LOW:
            begin
                sdu_len_next = full_len;
                res.channel  = channel_reg;
                if (full_len == 16'd0)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_EMPTY;
                end
                else if (eop)
                begin
                    res.valid  = 1'b1;
                    res.kind   = KIND_TRUNC;
                    res.length = full_len;
                end
                else
                begin
                    left_next  = full_len;
                    first_next = 1'b1;
                end
            end
            PH_LEN_HIGH:
            begin
                len_high_next = b;
                res.channel   = channel_reg;
                if (eop)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_TRUNC;
                end
            end
            PH_PAYLOAD:
            begin
                res.valid   = 1'b1;
                res.channel = channel_reg;
                res.length  = sdu_len_reg;
                if (last_byte)
                begin
                    res.kind  = KIND_PAYLOAD;
                    res.data  = b;
                    res.first = first_reg;
                    res.last  = 1'b1;
                    left_next = 16'd0;
                end
                else if (eop)
                begin
                    res.kind  = KIND_TRUNC;
                    left_next = 16'd0;
                end
                else
                begin
                    res.kind   = KIND_PAYLOAD;
                    res.data   = b;
                    res.first  = first_reg;
                    left_next  = left_reg - 16'd1;
                    first_next = 1'b0;
                end
            end
            PH_DISCARD:
            begin
                res = '0;
            end
            default:
            begin
                res = '0;
            end
        endcase
        if (eop)
        begin
            first_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SUBHDR;
            channel_reg  <= 6'd0;
            len_high_reg <= 8'd0;
            left_reg     <= 16'd0;
            sdu_len_reg  <= 16'd0;
            first_reg    <= 1'b1;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            channel_reg  <= channel_next;
            len_high_reg <= len_high_next;
            left_reg     <= left_next;
            sdu_len_reg  <= sdu_len_next;
            first_reg    <= first_next;
        end
    end

endmodule

[sv/mpd_out_stage.sv]
// ---------------------------------------------------------------------------
// MAC PDU demultiplexer result register
// Holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module mpd_out_stage
    import mpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     res,
    output logic        out_space,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [5:0]  channel_id,
    output logic [15:0] sdu_length,
    output logic [7:0]  sdu_byte,
    output logic        first_of_sdu,
    output logic        last_of_sdu
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = valid_reg;
    assign result_kind  = res_reg.kind;
    assign channel_id   = res_reg.channel;
    assign sdu_length   = res_reg.length;
    assign sdu_byte     = res_reg.data;
    assign first_of_sdu = res_reg.first;
    assign last_of_sdu  = res_reg.last;

endmodule

[sv/mac_pdu_demultiplexer_unit.sv]
// ---------------------------------------------------------------------------
// MAC PDU demultiplexer
// Splits a byte stream of MAC PDUs into tagged SDU bytes and status results.
// ---------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------------------
//  input    in_valid / in_ready  pdu_byte, end_of_pdu
//  output   out_valid/out_ready  result_kind, channel_id, sdu_length,
//                                sdu_byte, first_of_sdu, last_of_sdu
//
//  Throughput is one byte per clock unless a result byte meets a stalled output;
//  a result passes the input register, then the result register, to the output.
//  The parser state machine advances once per consumed byte.
//  Reset is asynchronous and returns the parser to the subheader phase at once.
//  When the output stalls, bytes that make no result (subheaders, length bytes,
//  discarded bytes) keep flowing; a byte with a result waits in the input reg.
//
module mac_pdu_demultiplexer_unit
    import mpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pdu_byte,
    input  logic        end_of_pdu,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [5:0]  channel_id,
    output logic [15:0] sdu_length,
    output logic [7:0]  sdu_byte,
    output logic        first_of_sdu,
    output logic        last_of_sdu
);

    // byte held for the parser
    in_item_t item;
    logic     item_valid;

    // parser handshake with the two registers
    logic     take;
    logic     out_space;
    result_t  res;

    mpd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pdu_byte   (pdu_byte),
        .end_of_pdu (end_of_pdu),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // single pass: each byte is classified and tagged combinationally
    mpd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_space  (out_space),
        .take       (take),
        .res        (res)
    );

    // a result is loaded only when the parser consumes a byte that makes one
    mpd_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (take && res.valid),
        .res          (res),
        .out_space    (out_space),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .channel_id   (channel_id),
        .sdu_length   (sdu_length),
        .sdu_byte     (sdu_byte),
        .first_of_sdu (first_of_sdu),
        .last_of_sdu  (last_of_sdu)
    );

endmodule

[sv/mpd_checker.sv]
// ---------------------------------------------------------------------------
// MAC PDU demultiplexer checker
// Port-level assertions on input and output transactions, bound to the top.
// ---------------------------------------------------------------------------
`include "mac_pdu_demultiplexer_unit_defines.svh"

module mpd_checker
    import mpd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  pdu_byte,
    input logic        end_of_pdu,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_kind,
    input logic [5:0]  channel_id,
    input logic [15:0] sdu_length,
    input logic [7:0]  sdu_byte,
    input logic        first_of_sdu,
    input logic        last_of_sdu
);

    // offered input transaction waits unchanged
    `MPD_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
        in_valid && $stable(pdu_byte) && $stable(end_of_pdu),
        "input changed while stalled")

    // stalled transaction keeps its payload
    `MPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(result_kind) && $stable(channel_id)
        && $stable(sdu_length) && $stable(sdu_byte),
        "output changed while stalled")

    `MPD_ASSERT_NOW(a_status_no_data, out_valid && result_kind != KIND_PAYLOAD,
        sdu_byte == 8'd0 && !first_of_sdu && !last_of_sdu,
        "status result carries payload marks")

    `MPD_ASSERT_NOW(a_reserved_id, out_valid && result_kind == KIND_RESERVED,
        channel_id > MAX_DATA_CHANNEL && sdu_length == 16'd0,
        "reserved result with valid id")

    `MPD_ASSERT_NOW(a_empty_sdu, out_valid && result_kind == KIND_EMPTY,
        channel_id <= MAX_DATA_CHANNEL && sdu_length == 16'd0,
        "empty SDU result malformed")

endmodule

bind mac_pdu_demultiplexer_unit mpd_checker u_mpd_checker (.*);

[tb/sdu_stream_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SDU stream checker
// Watches both channels of the MAC PDU demultiplexer, parses the accepted
// byte stream itself and compares every output transaction in order.
// ---------------------------------------------------------------------------
module sdu_stream_checker
    import mpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  pdu_byte,
    input  logic        end_of_pdu,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  result_kind,
    input  logic [5:0]  channel_id,
    input  logic [15:0] sdu_length,
    input  logic [7:0]  sdu_byte,
    input  logic        first_of_sdu,
    input  logic        last_of_sdu,
    output int          results_owed,
    output int          fail_count
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  chan;
        logic [15:0] len;
        logic [7:0]  data;
        logic        first;
        logic        last;
    } sdu_event_t;

    // parser state
    phase_t      parse_ph;
    logic [5:0]  cur_chan;
    logic        long_fmt;
    logic [7:0]  len_hi;
    logic [15:0] bytes_left;
    logic [15:0] sdu_len;
    logic        first_pending;

    sdu_event_t  owed_q[$];
    sdu_event_t  want;
    sdu_event_t  got_ev;
    int          errs = 0;

    // Advance the parser by one byte; returns 1 when the byte yields a result.
    function automatic bit parse_byte(input logic [7:0] b, input logic eop,
                                      output sdu_event_t ev);
        bit produced;
        bit len_complete;
        produced     = 1'b0;
        len_complete = 1'b0;
        ev           = '0;
        case (parse_ph)
            PH_LEN_SHORT:
            begin
                sdu_len      = {8'h00, b};
                len_complete = 1'b1;
            end
            PH_LEN_HIGH:
            begin
                len_hi = b;
                if (eop)
                begin
                    ev.kind  = KIND_TRUNC;
                    ev.chan  = cur_chan;
                    produced = 1'b1;
                end
                else
                    parse_ph = PH_LEN_LOW;
            end
            PH_LEN_LOW:
            begin
                sdu_len      = {len_hi, b};
                len_complete = 1'b1;
            end
            PH_PAYLOAD:
            begin
                produced = 1'b1;
                ev.chan  = cur_chan;
                ev.len   = sdu_len;
                if (bytes_left <= 16'd1)
                begin
                    ev.kind       = KIND_PAYLOAD;
                    ev.data       = b;
                    ev.first      = first_pending;
                    ev.last       = 1'b1;
                    bytes_left    = '0;
                    parse_ph      = PH_SUBHDR;
                    first_pending = 1'b1;
                end
                else if (eop)
                begin
                    ev.kind    = KIND_TRUNC;
                    bytes_left = '0;
                end
                else
                begin
                    ev.kind       = KIND_PAYLOAD;
                    ev.data       = b;
                    ev.first      = first_pending;
                    bytes_left    = bytes_left - 16'd1;
                    first_pending = 1'b0;
                end
            end
            PH_DISCARD:
                ;
            default:
            begin
                cur_chan = b[5:0];
                long_fmt = b[6];
                sdu_len  = '0;
                if (b[5:0] > MAX_DATA_CHANNEL)
                begin
                    ev.kind  = KIND_RESERVED;
                    ev.chan  = b[5:0];
                    produced = 1'b1;
                    parse_ph = PH_DISCARD;
                end
                else if (eop)
                begin
                    ev.kind  = KIND_TRUNC;
                    ev.chan  = b[5:0];
                    produced = 1'b1;
                end
                else
                    parse_ph = long_fmt ? PH_LEN_HIGH : PH_LEN_SHORT;
            end
        endcase

        if (len_complete)
        begin
            ev.chan = cur_chan;
            if (sdu_len == 16'd0)
            begin
                ev.kind       = KIND_EMPTY;
                produced      = 1'b1;
                parse_ph      = PH_SUBHDR;
                first_pending = 1'b1;
            end
            else if (eop)
            begin
                ev.kind  = KIND_TRUNC;
                ev.len   = sdu_len;
                produced = 1'b1;
            end
            else
            begin
                bytes_left    = sdu_len;
                first_pending = 1'b1;
                parse_ph      = PH_PAYLOAD;
            end
        end

        if (eop)
        begin
            parse_ph      = PH_SUBHDR;
            first_pending = 1'b1;
        end
        return produced;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_ph      = PH_SUBHDR;
            cur_chan      = '0;
            long_fmt      = 1'b0;
            len_hi        = '0;
            bytes_left    = '0;
            sdu_len       = '0;
            first_pending = 1'b1;
            owed_q.delete();
            results_owed <= 0;
            fail_count   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $error("unexpected output transaction: result_kind %0d channel_id %0d",
                           result_kind, channel_id);
                    errs++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    check_field("result_kind", 16'(want.kind), 16'(result_kind));
                    check_field("channel_id", 16'(want.chan), 16'(channel_id));
                    check_field("sdu_length", want.len, sdu_length);
                    check_field("sdu_byte", 16'(want.data), 16'(sdu_byte));
                    check_field("first_of_sdu", 16'(want.first), 16'(first_of_sdu));
                    check_field("last_of_sdu", 16'(want.last), 16'(last_of_sdu));
                end
            end
            if (in_valid && in_ready)
            begin
                if (parse_byte(pdu_byte, end_of_pdu, got_ev))
                    owed_q.push_back(got_ev);
            end
            results_owed <= owed_q.size();
            fail_count   <= errs;
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// MAC PDU demultiplexer testbench
// Drives PDU byte streams into the demultiplexer under random back-pressure
// and lets the SDU stream checker predict and compare every result.
// ---------------------------------------------------------------------------
//
//  Flow:
//    - reset held low, then released once
//    - a short directed set of PDUs: extreme ids, both length formats, empty
//      SDUs, reserved ids and truncation at each step but the low length byte
//    - three random passes of ~480 bytes each; the sender and receiver idle
//      rates swap after the first pass, the last pass runs with no idling and
//      opens with a long receiver hold-off so the block backs up
//    - drain, short tail, verdict
//
//  All inputs change only on the rising edge via nonblocking assignments;
//  the checker samples on the same edge, so both see pre-edge values.
//
module testbench;
    import mpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transaction at all
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
    localparam int PASS_BYTES     = 480;    // random bytes per pass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  pdu_byte;
    logic        end_of_pdu;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic [5:0]  channel_id;
    logic [15:0] sdu_length;
    logic [7:0]  sdu_byte;
    logic        first_of_sdu;
    logic        last_of_sdu;

    int          results_owed;
    int          fail_count;

    // stimulus control
    int          src_idle_pct;
    int          sink_idle_pct;
    logic        hold_req;
    int          bytes_sent;
    int          byte_goal;
    int          idle_run;
    logic [7:0]  pdu_q[$];      // bytes of the PDU being built

    mac_pdu_demultiplexer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pdu_byte     (pdu_byte),
        .end_of_pdu   (end_of_pdu),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .channel_id   (channel_id),
        .sdu_length   (sdu_length),
        .sdu_byte     (sdu_byte),
        .first_of_sdu (first_of_sdu),
        .last_of_sdu  (last_of_sdu)
    );

    sdu_stream_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pdu_byte     (pdu_byte),
        .end_of_pdu   (end_of_pdu),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .channel_id   (channel_id),
        .sdu_length   (sdu_length),
        .sdu_byte     (sdu_byte),
        .first_of_sdu (first_of_sdu),
        .last_of_sdu  (last_of_sdu),
        .results_owed (results_owed),
        .fail_count   (fail_count)
    );

    // 20 ns period
    always #10 clk = ~clk;

    // Watchdog: a long stretch with no transaction on either channel means
    // the block is hung or an expected result never came.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_run <= 0;
            else
                idle_run <= idle_run + 1;
            if (idle_run >= WATCHDOG_LIMIT)
            begin
                $display("** mac_pdu_demultiplexer_unit: FAILED **");
                $finish;
            end
        end
    end

    // Receiver: random ready at the current idle rate; once hold_req is
    // raised it drops ready for HOLD_CYCLES, counted here, exactly once.
    initial
    begin : receiver
        logic hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // One input transaction; optional idle gap before it. Valid is only
    // lowered inside a gap, so it never falls and rises in one time step.
    task automatic push_byte(input logic [7:0] b, input logic eop);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        pdu_byte   <= b;
        end_of_pdu <= eop;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Send the first n_bytes of the built PDU; the last one carries the end flag.
    task automatic send_pdu(input int n_bytes);
        for (int i = 0; i < n_bytes; i++)
            push_byte(pdu_q[i], i == n_bytes - 1);
        bytes_sent += n_bytes;
    endtask

    // Append one well-formed SDU: subheader, length field, payload.
    task automatic add_sdu();
        int          id_sel;
        int          len;
        logic [7:0]  sh;
        logic [15:0] len_v;
        id_sel = $urandom_range(9);
        len    = ($urandom_range(19) == 0) ? $urandom_range(11, 300)
                                           : $urandom_range(0, 10);
        len_v  = len[15:0];
        sh[7]  = 1'($urandom_range(1));                      // reserved bit, ignored
        sh[6]  = (len > 255) ? 1'b1 : ($urandom_range(3) == 0);
        if (id_sel == 0)
            sh[5:0] = 6'd0;                                  // control channel
        else if (id_sel == 1)
            sh[5:0] = MAX_DATA_CHANNEL;
        else
            sh[5:0] = 6'($urandom_range(1, 31));
        pdu_q.push_back(sh);
        if (sh[6])
            pdu_q.push_back(len_v[15:8]);
        pdu_q.push_back(len_v[7:0]);
        repeat (len)
            pdu_q.push_back(8'($urandom_range(255)));
    endtask

    // One random PDU: mostly well-formed, some cut short, some with a
    // reserved id, a few pure noise.
    task automatic random_pdu();
        int         pick;
        int         junk;
        logic [7:0] sh;
        pdu_q.delete();
        pick = $urandom_range(99);
        if (pick < 75)
        begin
            repeat ($urandom_range(1, 4)) add_sdu();
            send_pdu(pdu_q.size());
        end
        else if (pick < 88)
        begin
            repeat ($urandom_range(1, 3)) add_sdu();
            send_pdu($urandom_range(1, pdu_q.size()));
        end
        else if (pick < 95)
        begin
            if ($urandom_range(1))
                add_sdu();
            sh[7:6] = 2'($urandom_range(3));
            sh[5:0] = 6'($urandom_range(33, 63));
            pdu_q.push_back(sh);
            junk = $urandom_range(0, 5);
            repeat (junk)
                pdu_q.push_back(8'($urandom_range(255)));
            send_pdu(pdu_q.size());
            bytes_sent -= junk;         // dropped bytes do not count
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                pdu_q.push_back(8'($urandom_range(255)));
            send_pdu(pdu_q.size());
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        pdu_byte      = 8'h00;
        end_of_pdu    = 1'b0;
        hold_req      = 1'b0;
        src_idle_pct  = 7;
        sink_idle_pct = 81;
        bytes_sent    = 0;
        idle_run      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed PDUs (first idling pass settings) ---
        // control channel, one byte SDU with all bits set
        pdu_q = '{8'h00, 8'h01, 8'hFF};
        send_pdu(pdu_q.size());
        // reserved bit set, long format, channel 32; then an empty SDU
        pdu_q = '{8'hE0, 8'h00, 8'h02, 8'h00, 8'hA5, 8'h05, 8'h00};
        send_pdu(pdu_q.size());
        // reserved id: rest of the PDU dropped
        pdu_q = '{8'h21, 8'h12, 8'h34};
        send_pdu(pdu_q.size());
        // highest reserved id, ending on the subheader itself
        pdu_q = '{8'hFF};
        send_pdu(pdu_q.size());
        // end on a valid subheader
        pdu_q = '{8'h01};
        send_pdu(pdu_q.size());
        // end on the high length byte
        pdu_q = '{8'h41, 8'h00};
        send_pdu(pdu_q.size());
        // end right after a nonzero length
        pdu_q = '{8'h02, 8'h03};
        send_pdu(pdu_q.size());
        // maximum long length, cut inside the payload
        pdu_q = '{8'h5F, 8'hFF, 8'hFF, 8'h11, 8'h22};
        send_pdu(pdu_q.size());
        // long format with zero length
        pdu_q = '{8'h40, 8'h00, 8'h00};
        send_pdu(pdu_q.size());

        // --- random passes: slow receiver, then slow sender, then no idling ---
        for (int pass = 0; pass < 3; pass++)
        begin
            if (pass == 1)
            begin
                src_idle_pct  = 81;
                sink_idle_pct = 7;
            end
            else if (pass == 2)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                hold_req     <= 1'b1;   // receiver stalls while bytes keep coming
            end
            byte_goal = bytes_sent + PASS_BYTES;
            while (bytes_sent < byte_goal)
                random_pdu();
        end
        in_valid <= 1'b0;

        // let the checker count the last accepted byte before draining
        @(posedge clk);
        // drain: watchdog bounds this wait
        while (results_owed != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (fail_count == 0 && results_owed == 0)
            $display("** mac_pdu_demultiplexer_unit: PASSED **");
        else
            $display("** mac_pdu_demultiplexer_unit: FAILED **");
        $finish;
    end

endmodule

[mac_pdu_demultiplexer_unit.f]
+incdir+sv
sv/mpd_pkg.sv
sv/mpd_in_stage.sv
sv/mpd_parser.sv
sv/mpd_out_stage.sv
sv/mac_pdu_demultiplexer_unit.sv
sv/mpd_checker.sv
tb/sdu_stream_checker.sv
tb/testbench.sv
